FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/cdbe_pkg.sv
package cdbe_pkg;

    // Field widths
    localparam int IDX_W = 7;
    localparam int SMP_W = 16;
    localparam int OUT_W = 24;
    localparam int FRAC  = 15;

    // Request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Saturation limits
    localparam logic [OUT_W-1:0] SAT_MAX = 24'h7F_FFFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 24'h80_0000;

    // Twiddle table generation (Q30 Taylor series)
    localparam longint unsigned TWO_PI_Q30   = 64'd6746518852;
    localparam longint unsigned ONE_Q30      = 64'd1073741824;
    localparam int              SERIES_TERMS = 12;
    localparam longint unsigned SIN_DIV [1:SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
    localparam longint unsigned COS_DIV [1:SERIES_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
          64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic capture;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic idx_ok;
        logic acc_done;
    } t_dp_status;

endpackage

FILE: rtl/centered_dft_bin_engine_core.sv
// Centered direct DFT bin engine.
// Input stream: a load transfer (tuser = 0) writes one complex sample at
// item_index; a read transfer (tuser = 1) computes bin item_index of the
// centered DFT over all POINTS stored samples and returns one result.
// Loads and reads with an index at or beyond POINTS produce nothing.
// Loads may be sent back to back.
// A read walks the sample store one sample per cycle through a single
// complex multiply-accumulate, and tready stays low for that walk.
// i_cfg_we writes the direction bit (0 forward, 1 inverse with 1/POINTS
// scaling); write it only while no read is in flight.
// The result sits in an output register; while the receiver stalls, new
// loads and one further read are still taken, and that read holds its sum
// until the register is free.
// Reset clears control state and selects forward mode; the sample store is
// not cleared, so every entry must be loaded before a read.
module centered_dft_bin_engine_core import cdbe_pkg::*; #(
    parameter int POINTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // item_index[6:0], sample_re[22:7], sample_im[38:23]
    input  logic [0:0]  s_axis_tuser,  // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // bin_number[6:0], bin_re[30:7], bin_im[54:31]
    output logic [0:0]  m_axis_tuser,  // clipped[0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    t_dp_cmd                 w_cmd;
    t_dp_status              w_status;
    logic [IDX_W-1:0]        w_bin_number;
    logic signed [OUT_W-1:0] w_bin_re;
    logic signed [OUT_W-1:0] w_bin_im;
    logic                    w_clipped;

    // Sequencing
    cdbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_req    (s_axis_tuser[0]),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Store, twiddle table and MAC
    cdbe_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_index (s_axis_tdata[6:0]),
        .i_sample_re  (s_axis_tdata[22:7]),
        .i_sample_im  (s_axis_tdata[38:23]),
        .o_bin_number (w_bin_number),
        .o_bin_re     (w_bin_re),
        .o_bin_im     (w_bin_im),
        .o_clipped    (w_clipped)
    );

    assign m_axis_tdata = {1'b0, w_bin_im, w_bin_re, w_bin_number};
    assign m_axis_tuser = w_clipped;

endmodule

FILE: rtl/cdbe_datapath.sv
module cdbe_datapath import cdbe_pkg::*; #(
    parameter int POINTS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic [IDX_W-1:0]        i_item_index,
    input  logic signed [SMP_W-1:0] i_sample_re,
    input  logic signed [SMP_W-1:0] i_sample_im,
    output logic [IDX_W-1:0]        o_bin_number,
    output logic signed [OUT_W-1:0] o_bin_re,
    output logic signed [OUT_W-1:0] o_bin_im,
    output logic                    o_clipped
);

    localparam int LG      = $clog2(POINTS);
    localparam int HALF    = POINTS / 2;
    localparam int QUARTER = POINTS / 4;
    localparam int PROD_W  = 2 * SMP_W;
    localparam int TERM_W  = PROD_W + 1;
    localparam int ACC_W   = 40 + LG;
    localparam int SH_W    = ACC_W - FRAC;

    // Round a Q30 value to Q15, clamped to [0, 32767]
    function automatic logic [SMP_W-1:0] q30_to_q15(input longint v);
        longint vv;
        longint r;
        vv = (v < 0) ? 64'sd0 : v;
        r  = (vv + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r[SMP_W-1:0];
    endfunction

    // One table entry: {sin, cos} of 2*pi*p/POINTS
    function automatic logic [2*SMP_W-1:0] rom_entry(input int p);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned phi;
        longint unsigned x2;
        longint unsigned st;
        longint unsigned ct;
        longint          ssum;
        longint          csum;
        logic [SMP_W-1:0] c;
        logic [SMP_W-1:0] s;
        logic [SMP_W-1:0] co;
        logic [SMP_W-1:0] so;
        quad = longint'(p / QUARTER) & 64'd3;
        r    = longint'(p % QUARTER);
        phi  = (TWO_PI_Q30 * r) / POINTS;
        x2   = (phi * phi) >> 30;
        st   = phi;
        ct   = ONE_Q30;
        ssum = longint'(phi);
        csum = longint'(ONE_Q30);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            st = ((st * x2) >> 30) / SIN_DIV[k];
            ct = ((ct * x2) >> 30) / COS_DIV[k];
            if ((k % 2) == 1) begin
                ssum = ssum - longint'(st);
                csum = csum - longint'(ct);
            end else begin
                ssum = ssum + longint'(st);
                csum = csum + longint'(ct);
            end
        end
        c = q30_to_q15(csum);
        s = q30_to_q15(ssum);
        case (quad)
            64'd0: begin
                co = c;
                so = s;
            end
            64'd1: begin
                co = ~s + 16'd1;
                so = c;
            end
            64'd2: begin
                co = ~c + 16'd1;
                so = ~s + 16'd1;
            end
            default: begin
                co = s;
                so = ~c + 16'd1;
            end
        endcase
        return {so, co};
    endfunction

    // Twiddle table, one constant per phase
    logic [2*SMP_W-1:0] w_rom [POINTS];
    for (genvar p = 0; p < POINTS; p++) begin : g_rom
        localparam logic [2*SMP_W-1:0] ENT = rom_entry(p);
        assign w_rom[p] = ENT;
    end

    // Index decode
    logic [IDX_W+LG-1:0] w_idx_ext;
    logic [LG-1:0]       w_addr;
    logic                w_idx_ok;
    assign w_idx_ext = (IDX_W+LG)'(i_item_index);
    assign w_addr    = w_idx_ext[LG-1:0];
    assign w_idx_ok  = int'(i_item_index) < POINTS;

    // Configuration register
    logic r_inverse;

    // Sample store
    logic [2*SMP_W-1:0] r_mem [POINTS];
    logic [2*SMP_W-1:0] r_mem_q;

    // Walk state
    logic          r_run;
    logic [LG-1:0] r_j;
    logic [LG-1:0] r_um;
    logic [IDX_W-1:0] r_k;

    // Pipeline
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic                     r_last1, r_last2, r_last3, r_last4;
    logic [LG-1:0]            r_ph1;
    logic [2*SMP_W-1:0]       r_rom_q;
    logic signed [SMP_W-1:0]  r_re2, r_im2;
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [TERM_W-1:0] r_tre, r_tim;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic                     r_done;

    // Phase index (u * x) mod POINTS
    logic [LG-1:0]   w_xm;
    logic [2*LG-1:0] w_ph_prod;
    assign w_xm      = LG'(int'(r_j) + HALF);
    assign w_ph_prod = (2*LG)'(r_um) * (2*LG)'(w_xm);

    // Term selection by direction
    logic signed [TERM_W-1:0] w_tre, w_tim;
    always_comb begin
        if (r_inverse) begin
            w_tre = {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
            w_tim = {r_pd[PROD_W-1], r_pd} + {r_pc[PROD_W-1], r_pc};
        end else begin
            w_tre = {r_pa[PROD_W-1], r_pa} + {r_pb[PROD_W-1], r_pb};
            w_tim = {r_pc[PROD_W-1], r_pc} - {r_pd[PROD_W-1], r_pd};
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_idx_ok) begin
            r_mem[w_addr] <= {i_sample_im, i_sample_re};
        end
        r_mem_q <= r_mem[r_j];
    end

    // Control bits of the walk and pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
            r_run     <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_last1   <= 1'b0;
            r_last2   <= 1'b0;
            r_last3   <= 1'b0;
            r_last4   <= 1'b0;
            r_done    <= 1'b0;
            r_j       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_inverse <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_j   <= '0;
            end else if (r_run) begin
                r_j <= r_j + 1'b1;
                if (r_j == LG'(POINTS - 1)) begin
                    r_run <= 1'b0;
                end
            end
            r_v1    <= r_run;
            r_last1 <= r_run && (r_j == LG'(POINTS - 1));
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            r_v3    <= r_v2;
            r_last3 <= r_last2;
            r_v4    <= r_v3;
            r_last4 <= r_last3;
            r_done  <= r_v4 && r_last4;
        end
    end

    // Datapath registers: phase, twiddle, products, terms, accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_um <= LG'(int'(w_idx_ext) + HALF);
            r_k  <= i_item_index;
        end
        r_ph1   <= w_ph_prod[LG-1:0];
        r_rom_q <= w_rom[r_ph1];
        r_re2   <= r_mem_q[SMP_W-1:0];
        r_im2   <= r_mem_q[2*SMP_W-1:SMP_W];
        r_pa    <= r_re2 * $signed(r_rom_q[SMP_W-1:0]);
        r_pb    <= r_im2 * $signed(r_rom_q[2*SMP_W-1:SMP_W]);
        r_pc    <= r_im2 * $signed(r_rom_q[SMP_W-1:0]);
        r_pd    <= r_re2 * $signed(r_rom_q[2*SMP_W-1:SMP_W]);
        r_tre   <= w_tre;
        r_tim   <= w_tim;
        if (i_cmd.start) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v4) begin
            r_acc_re <= r_acc_re + {{(ACC_W-TERM_W){r_tre[TERM_W-1]}}, r_tre};
            r_acc_im <= r_acc_im + {{(ACC_W-TERM_W){r_tim[TERM_W-1]}}, r_tim};
        end
    end

    // Scale, floor and saturate
    logic signed [SH_W-1:0]  w_sh_re, w_sh_im;
    logic                    w_ovf_re, w_ovf_im;
    logic [OUT_W-1:0]        w_sat_re, w_sat_im;
    always_comb begin
        if (r_inverse) begin
            w_sh_re = SH_W'(r_acc_re >>> (FRAC + LG));
            w_sh_im = SH_W'(r_acc_im >>> (FRAC + LG));
        end else begin
            w_sh_re = SH_W'(r_acc_re >>> FRAC);
            w_sh_im = SH_W'(r_acc_im >>> FRAC);
        end
        w_ovf_re = !((&w_sh_re[SH_W-1:OUT_W-1]) || !(|w_sh_re[SH_W-1:OUT_W-1]));
        w_ovf_im = !((&w_sh_im[SH_W-1:OUT_W-1]) || !(|w_sh_im[SH_W-1:OUT_W-1]));
        if (w_ovf_re) begin
            w_sat_re = w_sh_re[SH_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            w_sat_re = w_sh_re[OUT_W-1:0];
        end
        if (w_ovf_im) begin
            w_sat_im = w_sh_im[SH_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            w_sat_im = w_sh_im[OUT_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            o_bin_number <= r_k;
            o_bin_re     <= w_sat_re;
            o_bin_im     <= w_sat_im;
            o_clipped    <= w_ovf_re || w_ovf_im;
        end
    end

    assign o_status.idx_ok   = w_idx_ok;
    assign o_status.acc_done = r_done;

endmodule

FILE: rtl/cdbe_ctrl.sv
module cdbe_ctrl import cdbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_req,
    output logic       o_s_tready,
    input  logic       i_m_tready,
    output logic       o_m_tvalid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_free;

    // Commands and next state
    always_comb begin
        w_accept      = i_s_tvalid && (r_state == S_IDLE);
        w_free        = !r_out_valid || i_m_tready;
        o_cmd.load    = w_accept && (i_s_req == REQ_LOAD);
        o_cmd.start   = w_accept && (i_s_req == REQ_READ) && i_status.idx_ok;
        o_cmd.capture = 1'b0;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.acc_done) begin
                    if (w_free) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

FILE: rtl/cdbe_checker.sv
`include "assert_macros.svh"

module cdbe_checker #(
    parameter int POINTS = 128
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic w_rd_xfer;
    logic w_ld_xfer;
    assign w_rd_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] &&
                       (int'(s_axis_tdata[6:0]) < POINTS);
    assign w_ld_xfer = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];

    // Stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    // A valid read closes the input for its walk
    `ASSERT_CLK(a_read_busy, i_clk, i_rst_n, w_rd_xfer |=> !s_axis_tready, "input open during bin walk")
    // A load never blocks the input
    `ASSERT_CLK(a_load_free, i_clk, i_rst_n, w_ld_xfer |=> s_axis_tready, "input closed after load")
    // A new result only appears at the end of a walk
    `ASSERT_NEVER(a_rise_busy, i_clk, i_rst_n, $rose(m_axis_tvalid) && $past(s_axis_tready), "result without a walk")

endmodule

bind centered_dft_bin_engine_core cdbe_checker #(
    .POINTS (POINTS)
) u_cdbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/centered_dft_bin_engine_core_tb.sv
`timescale 1ns / 1ps

module centered_dft_bin_engine_core_tb;
    import cdbe_pkg::*;

    localparam int POINTS       = 128;
    localparam int HALF         = POINTS / 2;
    localparam int LOG2_POINTS  = $clog2(POINTS);
    localparam int READ_LATENCY = POINTS + 5;
    localparam int TAIL_CYCLES  = READ_LATENCY + 8;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 380;
    localparam int IDLE_PCT     = 23;

    localparam longint unsigned TAU_Q30  = 64'd6746518852;
    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam longint          POS_LIM  = 64'sd8388607;
    localparam longint          NEG_LIM  = -64'sd8388608;

    // Directed table row kinds
    typedef enum logic [1:0] {OP_LOAD, OP_READ, OP_FILL, OP_CFG} t_row_op;

    // For OP_CFG the idx column carries the mode bit
    typedef struct {
        t_row_op          op;
        int               idx;
        logic [SMP_W-1:0] re;
        logic [SMP_W-1:0] im;
        bit               typed;
        logic [OUT_W-1:0] want_re;
        logic [OUT_W-1:0] want_im;
    } t_row;

    typedef struct packed {
        logic [IDX_W-1:0] bin;
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic             clip;
    } t_bin;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // item_index[6:0], sample_re[22:7], sample_im[38:23]
    logic [0:0]  s_axis_tuser;   // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // bin_number[6:0], bin_re[30:7], bin_im[54:31]
    logic [0:0]  m_axis_tuser;   // clipped[0]
    logic        i_cfg_we;
    logic        i_cfg_wdata;

    // Mirror of the block: sample store, direction bit, twiddle table
    logic        [SMP_W-1:0] store_re [POINTS];
    logic        [SMP_W-1:0] store_im [POINTS];
    logic                    inv_mode;
    logic signed [SMP_W-1:0] cos_q15 [POINTS];
    logic signed [SMP_W-1:0] sin_q15 [POINTS];

    t_bin pending_bins [$];
    t_row directed_rows [$];

    bit steady = 1'b0;
    int errors = 0;
    int n_loads = 0;
    int n_reads = 0;
    int n_checked = 0;
    int n_mode_writes = 0;
    int quiet_cycles = 0;

    centered_dft_bin_engine_core #(
        .POINTS(POINTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round a non-negative Q30 value to Q15, capped at the largest code
    function automatic logic [SMP_W-1:0] q30_to_q15(longint v);
        longint r;
        if (v < 0) v = 0;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        return r[SMP_W-1:0];
    endfunction

    // First-quadrant Taylor series, other quadrants by symmetry
    function automatic void build_twiddles();
        int quarter;
        int quad;
        longint unsigned r, phi, x2, st, ct;
        longint ssum, csum;
        logic [SMP_W-1:0] c, s;
        quarter = POINTS / 4;
        for (int p = 0; p < POINTS; p++) begin
            quad = (p / quarter) % 4;
            r    = longint'(p % quarter);
            phi  = (TAU_Q30 * r) / longint'(POINTS);
            x2   = (phi * phi) >> 30;
            st   = phi;
            ct   = UNIT_Q30;
            ssum = longint'(phi);
            csum = longint'(UNIT_Q30);
            for (int k = 1; k <= 12; k++) begin
                st = ((st * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                ct = ((ct * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    ssum -= longint'(st);
                    csum -= longint'(ct);
                end else begin
                    ssum += longint'(st);
                    csum += longint'(ct);
                end
            end
            c = q30_to_q15(csum);
            s = q30_to_q15(ssum);
            case (quad)
                0: begin cos_q15[p] = c;  sin_q15[p] = s;  end
                1: begin cos_q15[p] = -s; sin_q15[p] = c;  end
                2: begin cos_q15[p] = -c; sin_q15[p] = -s; end
                default: begin cos_q15[p] = s; sin_q15[p] = -c; end
            endcase
        end
    endfunction

    // One bin of the centered DFT over the mirrored store
    function automatic t_bin predict_bin(logic [IDX_W-1:0] k);
        t_bin   res;
        longint acc_re, acc_im, re, im, c, s;
        int     um, xm, ph, shift;
        um     = (int'(k) + HALF) % POINTS;
        acc_re = 0;
        acc_im = 0;
        for (int j = 0; j < POINTS; j++) begin
            xm = (j + HALF) % POINTS;
            ph = (um * xm) & (POINTS - 1);
            re = $signed(store_re[j]);
            im = $signed(store_im[j]);
            c  = cos_q15[ph];
            s  = sin_q15[ph];
            if (inv_mode) begin
                acc_re += re * c - im * s;
                acc_im += re * s + im * c;
            end else begin
                acc_re += re * c + im * s;
                acc_im += im * c - re * s;
            end
        end
        // arithmetic shift gives floor; inverse also divides by POINTS
        shift  = inv_mode ? FRAC + LOG2_POINTS : FRAC;
        acc_re = acc_re >>> shift;
        acc_im = acc_im >>> shift;
        res.clip = 1'b0;
        if (acc_re > POS_LIM) begin acc_re = POS_LIM; res.clip = 1'b1; end
        if (acc_re < NEG_LIM) begin acc_re = NEG_LIM; res.clip = 1'b1; end
        if (acc_im > POS_LIM) begin acc_im = POS_LIM; res.clip = 1'b1; end
        if (acc_im < NEG_LIM) begin acc_im = NEG_LIM; res.clip = 1'b1; end
        res.bin = k;
        res.re  = acc_re[OUT_W-1:0];
        res.im  = acc_im[OUT_W-1:0];
        return res;
    endfunction

    // Biased toward the extremes of the 16-bit range
    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(t_row_op op, int idx, int re = 0, int im = 0,
                           bit typed = 1'b0, int want_re = 0, int want_im = 0);
        t_row row;
        row.op      = op;
        row.idx     = idx;
        row.re      = re[SMP_W-1:0];
        row.im      = im[SMP_W-1:0];
        row.typed   = typed;
        row.want_re = want_re[OUT_W-1:0];
        row.want_im = want_im[OUT_W-1:0];
        directed_rows = {directed_rows, row};
    endtask

    // Drive one input item and wait for its transfer; valid is left high
    task automatic send_item(logic req, logic [IDX_W-1:0] idx,
                             logic [SMP_W-1:0] re, logic [SMP_W-1:0] im,
                             bit typed = 1'b0, t_bin want = '0);
        t_bin exp_bin;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, im, re, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (req == REQ_LOAD) begin
            store_re[idx] = re;
            store_im[idx] = im;
            n_loads++;
        end else begin
            exp_bin = typed ? want : predict_bin(idx);
            pending_bins = {pending_bins, exp_bin};
            n_reads++;
        end
    endtask

    // Hold off the sender until every bin is back and the engine is quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        inv_mode = mode;
        n_mode_writes++;
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result checker
    always @(posedge i_clk) begin : check_bins
        t_bin got;
        t_bin want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[6:0], m_axis_tdata[30:7], m_axis_tdata[54:31], m_axis_tuser[0]};
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected bin %0d re %0d im %0d", $time, got.bin,
                         $signed(got.re), $signed(got.im));
                errors++;
            end else begin
                want = pending_bins.pop_front();
                n_checked++;
                if (got.bin !== want.bin) begin
                    $display("%0t: bin_number expected %0d got %0d", $time, want.bin, got.bin);
                    errors++;
                end
                if (got.re !== want.re) begin
                    $display("%0t: bin %0d bin_re expected %0d got %0d", $time, want.bin,
                             $signed(want.re), $signed(got.re));
                    errors++;
                end
                if (got.im !== want.im) begin
                    $display("%0t: bin %0d bin_im expected %0d got %0d", $time, want.bin,
                             $signed(want.im), $signed(got.im));
                    errors++;
                end
                if (got.clip !== want.clip) begin
                    $display("%0t: bin %0d clipped expected %0b got %0b", $time, want.bin,
                             want.clip, got.clip);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer or register write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_row row;
        t_bin want;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_LOAD;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        i_rst_n       <= 1'b0;
        inv_mode = 1'b0;
        build_twiddles();

        // zero store: every bin is zero
        add_row(OP_FILL, 0, 0, 0);
        add_row(OP_READ, 0, 0, 0, 1'b1, 0, 0);
        add_row(OP_READ, 127, 0, 0, 1'b1, 0, 0);
        // extremes at the center sample and the edges
        add_row(OP_LOAD, 64, 32767, -32768);
        add_row(OP_LOAD, 0, -32768, 32767);
        add_row(OP_LOAD, 127, -1, 1);
        add_row(OP_LOAD, 1, 21845, -21846);
        add_row(OP_READ, 64);
        add_row(OP_READ, 0);
        add_row(OP_READ, 127);
        add_row(OP_READ, 96);
        // inverse direction
        add_row(OP_CFG, 1);
        add_row(OP_READ, 64);
        add_row(OP_READ, 0);
        add_row(OP_READ, 33);
        // full-scale negative store: DC bin is the largest sum
        add_row(OP_FILL, 0, -32768, -32768);
        add_row(OP_READ, 64, 0, 0, 1'b1, -32767, -32767);
        add_row(OP_CFG, 0);
        add_row(OP_READ, 64, 0, 0, 1'b1, -4194176, -4194176);
        add_row(OP_FILL, 0, 32767, 32767);
        add_row(OP_READ, 64);
        add_row(OP_READ, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        // Directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.op)
                OP_LOAD: send_item(REQ_LOAD, row.idx[IDX_W-1:0], row.re, row.im);
                OP_READ: begin
                    want = {row.idx[IDX_W-1:0], row.want_re, row.want_im, 1'b0};
                    send_item(REQ_READ, row.idx[IDX_W-1:0], 16'h0, 16'h0, row.typed, want);
                end
                OP_FILL: begin
                    for (int j = 0; j < POINTS; j++) begin
                        send_item(REQ_LOAD, IDX_W'(j), row.re, row.im);
                    end
                end
                default: write_mode(row.idx[0]);
            endcase
        end

        // Random part: fresh store, then mixed loads and reads
        for (int j = 0; j < POINTS; j++) begin
            send_item(REQ_LOAD, IDX_W'(j), rand_sample(), rand_sample());
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 150 && n < 300);
            if (n % 150 == 149) write_mode(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                send_item(REQ_READ, IDX_W'($urandom_range(0, POINTS - 1)),
                          16'($urandom), 16'($urandom));
            end else begin
                send_item(REQ_LOAD, IDX_W'($urandom_range(0, POINTS - 1)),
                          rand_sample(), rand_sample());
            end
        end
        steady = 1'b0;
        wait_idle();

        $display("Ran %0d sample loads and %0d bin reads, %0d bins checked.",
                 n_loads, n_reads, n_checked);
        $display("Direction written %0d times, forward and inverse, with random stalls.",
                 n_mode_writes);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: centered_dft_bin_engine_core.f
+incdir+rtl
rtl/cdbe_pkg.sv
rtl/cdbe_datapath.sv
rtl/cdbe_ctrl.sv
rtl/centered_dft_bin_engine_core.sv
rtl/cdbe_checker.sv
tb/centered_dft_bin_engine_core_tb.sv
